### rtl/baro_pkg.sv
// Shared constants for the pressure and temperature compensation pipeline.
`default_nettype none

package baro_pkg;

  localparam int RAW_W   = 24;
  localparam int COEF_W  = 16;
  localparam int TEMP_W  = 19;
  localparam int PRES_W  = 32;
  localparam int IDX_W   = 3;
  localparam int LATENCY = 6;

  localparam logic [RAW_W-1:0]  RAW_LOW   = 24'd1000000;
  localparam logic [RAW_W-1:0]  RAW_HIGH  = 24'd16000000;
  localparam logic [TEMP_W-1:0] TEMP_BASE = 19'd2000;

  localparam logic [IDX_W-1:0] REG_SENS      = 3'd0;
  localparam logic [IDX_W-1:0] REG_OFFSET    = 3'd1;
  localparam logic [IDX_W-1:0] REG_SENS_TC   = 3'd2;
  localparam logic [IDX_W-1:0] REG_OFFSET_TC = 3'd3;
  localparam logic [IDX_W-1:0] REG_REF_TEMP  = 3'd4;
  localparam logic [IDX_W-1:0] REG_TEMP_TC   = 3'd5;

endpackage

`default_nettype wire

### rtl/baro_pressure_temp_compensation_unit.sv
// Six-stage pipelined first-order pressure and temperature compensation.
// done follows an accepted start through the valid bits v1 to v5 and is registered with the result.
// Throughput: one transaction per cycle; the pipeline never stalls.
// The widest product (raw pressure times sensitivity) is split over two stages.
// Reset (rst, synchronous): calibration registers and stage valid bits clear;
// busy is high while rst is high, so no transaction enters during reset.
`default_nettype none

module baro_pressure_temp_compensation_unit (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              start,
  output logic                             busy,
  input  wire  [baro_pkg::RAW_W-1:0]       raw_pressure,
  input  wire  [baro_pkg::RAW_W-1:0]       raw_temp,
  input  wire                              wr_en,
  input  wire  [baro_pkg::IDX_W-1:0]       wr_index,
  input  wire  [baro_pkg::COEF_W-1:0]      wr_data,
  output logic                             done,
  output logic signed [baro_pkg::TEMP_W-1:0] temp_centideg,
  output logic signed [baro_pkg::PRES_W-1:0] pressure_pa,
  output logic                             sample_valid
);
  import baro_pkg::*;

  // calibration registers
  logic [COEF_W-1:0] sens_coeff, offset_coeff, sens_temp_coeff;
  logic [COEF_W-1:0] offset_temp_coeff, ref_temp_word, temp_slope_coeff;

  always_ff @(posedge clk) begin
    if (rst) begin
      sens_coeff        <= '0;
      offset_coeff      <= '0;
      sens_temp_coeff   <= '0;
      offset_temp_coeff <= '0;
      ref_temp_word     <= '0;
      temp_slope_coeff  <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_SENS:      sens_coeff        <= wr_data;
        REG_OFFSET:    offset_coeff      <= wr_data;
        REG_SENS_TC:   sens_temp_coeff   <= wr_data;
        REG_OFFSET_TC: offset_temp_coeff <= wr_data;
        REG_REF_TEMP:  ref_temp_word     <= wr_data;
        REG_TEMP_TC:   temp_slope_coeff  <= wr_data;
        default: ;
      endcase
    end
  end

  assign busy = rst;

  logic accept;
  assign accept = start && !busy;

  logic p_ok, t_ok;
  assign p_ok = (raw_pressure != '0) && (raw_pressure >= RAW_LOW) && (raw_pressure <= RAW_HIGH);
  assign t_ok = (raw_temp != '0) && (raw_temp >= RAW_LOW) && (raw_temp <= RAW_HIGH);

  logic v1, v2, v3, v4, v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= accept;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      v5   <= v4;
      done <= v5;
    end
  end

  // stage 1: temperature difference and range check
  logic signed [RAW_W:0] dt_next, dt1;
  logic [RAW_W-1:0]      d1_s1;
  logic                  ok1;

  assign dt_next = $signed({1'b0, raw_temp}) - $signed({1'b0, ref_temp_word, 8'b0});

  always_ff @(posedge clk) begin
    dt1   <= dt_next;
    d1_s1 <= raw_pressure;
    ok1   <= p_ok && t_ok;
  end

  // stage 2: the three dT products
  localparam int PW = RAW_W + COEF_W + 2;
  logic signed [PW-1:0] prod_temp, prod_off, prod_sens;
  logic [RAW_W-1:0]     d1_s2;
  logic                 ok2;

  always_ff @(posedge clk) begin
    prod_temp <= dt1 * $signed({1'b0, temp_slope_coeff});
    prod_off  <= dt1 * $signed({1'b0, offset_temp_coeff});
    prod_sens <= dt1 * $signed({1'b0, sens_temp_coeff});
    d1_s2     <= d1_s1;
    ok2       <= ok1;
  end

  // stage 3: temperature, offset and sensitivity
  localparam int OFF_W  = 36;
  localparam int SENS_W = 35;
  localparam int LO_W   = 18;

  logic signed [PW-1:0]     temp_shr, off_shr, sens_shr;
  logic signed [OFF_W-1:0]  off_next, off3;
  logic signed [SENS_W-1:0] sens_next, sens3;
  logic [TEMP_W-1:0]        temp_next, temp3;
  logic [RAW_W-1:0]         d1_s3;
  logic                     ok3;

  assign temp_shr  = prod_temp >>> 23;
  assign off_shr   = prod_off >>> 6;
  assign sens_shr  = prod_sens >>> 7;
  assign temp_next = temp_shr[TEMP_W-1:0] + TEMP_BASE;
  assign off_next  = $signed({3'b0, offset_coeff, 17'b0}) + off_shr[OFF_W-1:0];
  assign sens_next = $signed({3'b0, sens_coeff, 16'b0}) + sens_shr[SENS_W-1:0];

  always_ff @(posedge clk) begin
    temp3 <= temp_next;
    off3  <= off_next;
    sens3 <= sens_next;
    d1_s3 <= d1_s2;
    ok3   <= ok2;
  end

  // stage 4: raw pressure times sensitivity as two partial products
  localparam int PPW = RAW_W + LO_W;
  localparam int SUMW = RAW_W + SENS_W + 2;
  logic [PPW-1:0]           pp_lo;
  logic signed [PPW-1:0]    pp_hi;
  logic signed [OFF_W-1:0]  off4;
  logic [TEMP_W-1:0]        temp4;
  logic                     ok4;

  always_ff @(posedge clk) begin
    pp_lo <= d1_s3 * sens3[LO_W-1:0];
    pp_hi <= $signed({1'b0, d1_s3}) * $signed(sens3[SENS_W-1:LO_W]);
    off4  <= off3;
    temp4 <= temp3;
    ok4   <= ok3;
  end

  // stage 5: combine the partial products
  logic signed [SUMW-1:0]   hi_ext, lo_ext, prod_next, prod5;
  logic signed [OFF_W-1:0]  off5;
  logic [TEMP_W-1:0]        temp5;
  logic                     ok5;

  assign hi_ext    = SUMW'(pp_hi);
  assign lo_ext    = $signed({{(SUMW-PPW){1'b0}}, pp_lo});
  assign prod_next = (hi_ext <<< LO_W) + lo_ext;

  always_ff @(posedge clk) begin
    prod5 <= prod_next;
    off5  <= off4;
    temp5 <= temp4;
    ok5   <= ok4;
  end

  // stage 6: scale, subtract offset, scale again; zero the fields on a bad sample
  localparam int DW = 48;
  logic signed [SUMW-1:0] x_shr;
  logic signed [DW-1:0]   x_ext, off_ext, diff;

  assign x_shr   = prod5 >>> 21;
  assign x_ext   = $signed(x_shr[DW-1:0]);
  assign off_ext = DW'(off5);
  assign diff    = x_ext - off_ext;

  always_ff @(posedge clk) begin
    if (ok5) begin
      temp_centideg <= $signed(temp5);
      pressure_pa   <= $signed(diff[15 +: PRES_W]);
    end else begin
      temp_centideg <= '0;
      pressure_pa   <= '0;
    end
    sample_valid <= ok5;
  end

endmodule

`default_nettype wire

### rtl/baro_chk.sv
// Port-level checker for the compensation pipeline, bound to the top level.
`default_nettype none

module baro_chk (
  input wire                              clk,
  input wire                              rst,
  input wire                              start,
  input wire                              busy,
  input wire [baro_pkg::RAW_W-1:0]        raw_pressure,
  input wire                              done,
  input wire signed [baro_pkg::TEMP_W-1:0] temp_centideg,
  input wire signed [baro_pkg::PRES_W-1:0] pressure_pa,
  input wire                              sample_valid
);
  import baro_pkg::*;

  logic accept;
  assign accept = start && !busy;

  // every accepted transaction yields a result after a fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##6 done)
    else $error("result missing after accepted transaction");

  // no result appears without a transaction behind it
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 6))
    else $error("result without accepted transaction");

  // a rejected sample carries zero fields
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (done && !sample_valid) |-> (pressure_pa == '0 && temp_centideg == '0))
    else $error("rejected sample has nonzero fields");

  // a raw pressure below range must come out flagged invalid
  a_range: assert property (@(posedge clk) disable iff (rst)
    (accept && raw_pressure < RAW_LOW) |-> ##6 (done && !sample_valid))
    else $error("out-of-range raw pressure not flagged");

endmodule

bind baro_pressure_temp_compensation_unit baro_chk u_baro_chk (.*);

`default_nettype wire
